@@ hdl/fibmp_pkg.sv @@
// Shared constants, types and helper functions for the Fibonacci modular power block.
package fibmp_pkg;

    // Field and datapath widths
    localparam int unsigned VAL_W  = 30;
    localparam int unsigned IDX_W  = 63;
    localparam int unsigned CNT_W  = 6;

    // Modulus and Barrett reduction constant floor(2^60 / P)
    localparam logic [VAL_W-1:0] PRIME     = 30'd1000000007;
    localparam logic [31:0]      PRIME_X2  = 32'd2000000014;
    localparam logic [60:0]      TWO_60    = 61'd1 << 60;
    localparam logic [30:0]      BARRETT_M = 31'(TWO_60 / 61'(PRIME));

    // Index of the top bit of n, first bit processed
    localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(IDX_W - 1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ISSUE,
        ST_WAIT,
        ST_COMB,
        ST_FINISH
    } fibmp_state_t;

    // Product slots issued per index bit
    typedef enum logic [1:0] {
        PROD_BB,
        PROD_CC,
        PROD_BS
    } fibmp_prod_t;

    // Multiplier request and response
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } fibmp_mul_req_t;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] r;
    } fibmp_mul_rsp_t;

    // Reduce a value below 3*P into 0..P-1
    function automatic logic [VAL_W-1:0] mod_reduce3(input logic [31:0] v);
        logic [31:0] res;
        if (v >= PRIME_X2) begin
            res = v - PRIME_X2;
        end else if (v >= 32'(PRIME)) begin
            res = v - 32'(PRIME);
        end else begin
            res = v;
        end
        return res[VAL_W-1:0];
    endfunction

endpackage

@@ hdl/fibonacci_mod_matrix_power_top.sv @@
// Top level: Fibonacci F(n+1) mod 1000000007 by fast doubling on a shared modular multiplier.
//
// Each input item carries a 63-bit index n; one result item returns F(n+1) mod 1000000007.
// The block walks all 63 bits of n from the top, keeping the pair (F(k), F(k+1)) of the
// matrix power. Each bit takes a prepare state, three modular products issued back to back
// into one five-stage multiplier, a wait on the last product, and a combine state. An item
// is taken only after the result of the previous one has moved to the output register.
// s_tready is high only while the block is idle; the finished result sits in an output
// register so the next item can be taken while it waits on m_tready.
module fibonacci_mod_matrix_power_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] index_n, [63] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] fib_value, [31:30] zero
);

    localparam int unsigned VW = fibmp_pkg::VAL_W;

    fibmp_pkg::fibmp_state_t   state_reg, state_next;
    logic [fibmp_pkg::IDX_W-1:0] n_reg, n_next;
    logic [fibmp_pkg::CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [VW-1:0] b_reg, b_next;
    logic [VW-1:0] c_reg, c_next;
    logic [VW-1:0] s_reg, s_next;
    logic [1:0]    issue_cnt_reg, issue_cnt_next;
    logic [1:0]    recv_cnt_reg, recv_cnt_next;
    logic [VW-1:0] bb_reg, cc_reg, bs_reg;
    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] out_data_reg, out_data_next;
    logic [VW-1:0] sq_sum;

    fibmp_pkg::fibmp_mul_req_t mul_req;
    fibmp_pkg::fibmp_mul_rsp_t mul_rsp;

    fibmp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // F(2k+1) = F(k)^2 + F(k+1)^2
    assign sq_sum = fibmp_pkg::mod_reduce3(32'(bb_reg) + 32'(cc_reg));

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fibmp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
            recv_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            issue_cnt_reg <= issue_cnt_next;
            recv_cnt_reg  <= recv_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        s_reg        <= s_next;
        out_data_reg <= out_data_next;
        if (mul_rsp.valid) begin
            case (fibmp_pkg::fibmp_prod_t'(recv_cnt_reg))
                fibmp_pkg::PROD_BB: bb_reg <= mul_rsp.r;
                fibmp_pkg::PROD_CC: cc_reg <= mul_rsp.r;
                default:            bs_reg <= mul_rsp.r;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        bit_cnt_next   = bit_cnt_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        issue_cnt_next = issue_cnt_reg;
        recv_cnt_next  = mul_rsp.valid ? recv_cnt_reg + 2'd1 : recv_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        mul_req.valid  = 1'b0;
        mul_req.a      = b_reg;
        mul_req.b      = b_reg;

        case (state_reg)
            fibmp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_next       = s_tdata[fibmp_pkg::IDX_W-1:0];
                    b_next       = '0;
                    c_next       = VW'(1);
                    bit_cnt_next = fibmp_pkg::TOP_BIT;
                    state_next   = fibmp_pkg::ST_PREP;
                end
            end
            fibmp_pkg::ST_PREP: begin
                // 2*F(k+1) - F(k), kept positive by adding P
                s_next = fibmp_pkg::mod_reduce3({c_reg, 1'b0} + 32'(fibmp_pkg::PRIME)
                                                - 32'(b_reg));
                issue_cnt_next = '0;
                recv_cnt_next  = '0;
                state_next     = fibmp_pkg::ST_ISSUE;
            end
            fibmp_pkg::ST_ISSUE: begin
                mul_req.valid = 1'b1;
                case (fibmp_pkg::fibmp_prod_t'(issue_cnt_reg))
                    fibmp_pkg::PROD_BB: begin
                        mul_req.a = b_reg;
                        mul_req.b = b_reg;
                    end
                    fibmp_pkg::PROD_CC: begin
                        mul_req.a = c_reg;
                        mul_req.b = c_reg;
                    end
                    default: begin
                        mul_req.a = b_reg;
                        mul_req.b = s_reg;
                    end
                endcase
                issue_cnt_next = issue_cnt_reg + 2'd1;
                if (fibmp_pkg::fibmp_prod_t'(issue_cnt_reg) == fibmp_pkg::PROD_BS) begin
                    state_next = fibmp_pkg::ST_WAIT;
                end
            end
            fibmp_pkg::ST_WAIT: begin
                if (mul_rsp.valid &&
                    fibmp_pkg::fibmp_prod_t'(recv_cnt_reg) == fibmp_pkg::PROD_BS) begin
                    state_next = fibmp_pkg::ST_COMB;
                end
            end
            fibmp_pkg::ST_COMB: begin
                // Doubling step, then one step forward when the index bit is set
                if (n_reg[fibmp_pkg::IDX_W-1]) begin
                    b_next = sq_sum;
                    c_next = fibmp_pkg::mod_reduce3(32'(bs_reg) + 32'(sq_sum));
                end else begin
                    b_next = bs_reg;
                    c_next = sq_sum;
                end
                n_next = n_reg << 1;
                if (bit_cnt_reg == '0) begin
                    state_next = fibmp_pkg::ST_FINISH;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    state_next   = fibmp_pkg::ST_PREP;
                end
            end
            fibmp_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = c_reg;
                    state_next     = fibmp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fibmp_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

@@ hdl/fibmp_modmul.sv @@
// Five-stage pipelined modular multiplier (a*b mod P) using Barrett reduction.
module fibmp_modmul (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fibmp_pkg::fibmp_mul_req_t req,
    output fibmp_pkg::fibmp_mul_rsp_t rsp
);

    logic [4:0]  vld_reg;
    logic [59:0] x_reg;
    logic [61:0] t_reg;
    logic [31:0] xlo2_reg;
    logic [31:0] xlo3_reg;
    logic [31:0] qp_reg;
    logic [31:0] r_reg;
    logic [fibmp_pkg::VAL_W-1:0] res_reg;
    logic [60:0] qp_full;

    // Quotient estimate times modulus; only the low word matters for the remainder
    assign qp_full = 61'(t_reg[61:31]) * 61'(fibmp_pkg::PRIME);

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], req.valid};
        end
    end

    // Datapath: product, quotient estimate, q*P, raw remainder, final correction
    always_ff @(posedge aclk) begin
        x_reg    <= 60'(req.a) * 60'(req.b);
        t_reg    <= 62'(x_reg[59:29]) * 62'(fibmp_pkg::BARRETT_M);
        xlo2_reg <= x_reg[31:0];
        qp_reg   <= qp_full[31:0];
        xlo3_reg <= xlo2_reg;
        r_reg    <= xlo3_reg - qp_reg;
        res_reg  <= fibmp_pkg::mod_reduce3(r_reg);
    end

    assign rsp.valid = vld_reg[4];
    assign rsp.r     = res_reg;

endmodule

@@ hdl/fibmp_checker.sv @@
// Port-level checker for the Fibonacci modular power block, bound to the top level.
module fibmp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result item holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // One item at a time: the block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item still in work");

    // A result cannot appear on the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared immediately after accept");

    // Results are fully reduced and padding bits stay zero
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata < 32'd1000000007))
        else $error("result not reduced modulo the prime");

endmodule

bind fibonacci_mod_matrix_power_top fibmp_checker u_fibmp_checker (.*);
